// ----- rtl/koch_curve_segment_generator_top_assert.svh -----
// Assertion macros used by the checker file of the Koch segment generator.
`ifndef KOCH_CURVE_SEGMENT_GENERATOR_TOP_ASSERT_SVH
`define KOCH_CURVE_SEGMENT_GENERATOR_TOP_ASSERT_SVH

// Same-cycle implication, sampled on i_clk and switched off during reset.
`define KCSG_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and switched off during reset.
`define KCSG_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/kcsg_pkg.sv -----
package kcsg_pkg;

    localparam int DEF_MAX_ORDER   = 3;
    localparam int DEF_COORD_WIDTH = 16;

    // Coefficients in Q0.16, carried as signed 18-bit multiplier operands.
    localparam int COEF_W = 18;
    localparam logic signed [COEF_W-1:0] C_THIRD_Q16 = 18'sd21845;
    localparam logic signed [COEF_W-1:0] C_COS60_Q16 = 18'sd32768;
    localparam logic signed [COEF_W-1:0] C_SIN60_Q16 = 18'sd56756;

    // Half an LSB of the Q16 result, the starting value of every rounded sum.
    localparam int ROUND_HALF = 32768;
    localparam int FRAC_BITS  = 16;

    localparam int LVL_W = 2;

    typedef struct packed {
        logic en;
        logic accum;
        logic sub;
    } t_mac_ctl;

endpackage

// ----- rtl/kcsg_ram.sv -----
module kcsg_ram #(
    parameter int WIDTH  = 66,
    parameter int DEPTH  = 10,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/kcsg_mac.sv -----
module kcsg_mac #(
    parameter int OP_W  = 17,
    parameter int ACC_W = 36
) (
    input  logic                                 i_clk,
    input  kcsg_pkg::t_mac_ctl                   i_ctl,
    input  logic signed [OP_W-1:0]               i_a,
    input  logic signed [kcsg_pkg::COEF_W-1:0]   i_b,
    output logic signed [ACC_W-1:0]              o_acc
);

    import kcsg_pkg::*;

    logic signed [OP_W+COEF_W-1:0] w_prod;
    logic signed [ACC_W-1:0]       w_term;
    logic signed [ACC_W-1:0]       w_base;
    logic signed [ACC_W-1:0]       n_acc;
    logic signed [ACC_W-1:0]       r_acc;

    always_comb begin
        w_prod = i_a * i_b;
        w_term = i_ctl.sub ? -ACC_W'(w_prod) : ACC_W'(w_prod);
        // A fresh sum starts from half an LSB so that the later shift rounds.
        w_base = i_ctl.accum ? r_acc : ACC_W'(ROUND_HALF);
        n_acc  = w_base + w_term;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

// ----- rtl/koch_curve_segment_generator_top.sv -----
// Koch curve segment generator.
// Command channel: present a segment (start and end point, signed Q8.8) and an
// order of 0 to 3 with i_start high; the beat is taken at an edge where o_busy
// is low. Orders above MAX_ORDER are clamped to it.
// Result channel: each emitted segment is shown for exactly one cycle with
// o_valid high; o_last_segment marks the final one of the command. Segments
// come in drawing order, 4^order of them.
// Pending segments live in a small stack RAM with a registered read.
// Each split of a segment runs on the shared multiply-accumulate unit and the
// stack port. o_busy stays high until the edge that registers the last beat,
// so a new command may be taken in the same cycle as that beat.
// Reset (synchronous, active low) empties the stack and returns to idle; the
// stack contents themselves are not cleared. The receiver cannot stall.
module koch_curve_segment_generator_top #(
    parameter int MAX_ORDER   = kcsg_pkg::DEF_MAX_ORDER,
    parameter int COORD_WIDTH = kcsg_pkg::DEF_COORD_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic signed [COORD_WIDTH-1:0] i_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_end_y,
    input  logic [kcsg_pkg::LVL_W-1:0]    i_depth_order,
    output logic                          o_valid,
    output logic signed [COORD_WIDTH-1:0] o_out_start_x,
    output logic signed [COORD_WIDTH-1:0] o_out_start_y,
    output logic signed [COORD_WIDTH-1:0] o_out_end_x,
    output logic signed [COORD_WIDTH-1:0] o_out_end_y,
    output logic                          o_last_segment
);

    import kcsg_pkg::*;

    localparam int W       = COORD_WIDTH;
    localparam int DEPTH   = 3 * MAX_ORDER + 1;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TW      = $clog2(DEPTH + 1);
    localparam int ENT_W   = 4 * W + LVL_W;
    localparam int OP_W    = W + 1;
    localparam int ACC_W   = W + 20;
    localparam int SW      = W + 4;

    typedef enum logic [3:0] {
        S_IDLE, S_POP, S_EXAM, S_DX, S_DY, S_CX0, S_CX1,
        S_CY0, S_CY1, S_CFIN, S_P1, S_P2, S_P3, S_P4
    } t_state;

    t_state r_state;
    logic [TW-1:0] r_top;
    logic [LVL_W-1:0] r_lvl;
    logic signed [W-1:0] r_x0, r_y0, r_x1, r_y1;
    logic signed [W-1:0] r_ax, r_ay, r_bx, r_by, r_cx, r_cy;
    logic signed [W:0]   r_dx, r_dy;
    logic signed [W+1:0] r_cx_off;
    logic r_valid, r_last;
    logic signed [W-1:0] r_out_sx, r_out_sy, r_out_ex, r_out_ey;

    logic [TW-1:0]      w_top_m1;
    logic               w_wr_en;
    logic [AW-1:0]      w_wr_addr;
    logic [ENT_W-1:0]   w_wr_data;
    logic               w_rd_en;
    logic [ENT_W-1:0]   w_rd_data;
    logic [LVL_W-1:0]   w_rd_lvl;
    logic [LVL_W-1:0]   w_order;
    logic               w_push;
    t_mac_ctl           w_mac_ctl;
    logic signed [OP_W-1:0]   w_mac_a;
    logic signed [COEF_W-1:0] w_mac_b;
    logic signed [ACC_W-1:0]  w_acc;
    logic signed [W+1:0]      w_acc_q;
    logic signed [W:0]        w_diff_x, w_diff_y;

    function automatic logic signed [W-1:0] sat(input logic signed [SW-1:0] v);
        logic [4:0] top_bits;
        top_bits = v[SW-1:W-1];
        if ((&top_bits) || !(|top_bits)) begin
            return v[W-1:0];
        end else if (v[SW-1]) begin
            return {1'b1, {(W-1){1'b0}}};
        end else begin
            return {1'b0, {(W-1){1'b1}}};
        end
    endfunction

    assign w_top_m1 = r_top - TW'(1);
    assign w_rd_lvl = w_rd_data[ENT_W-1:4*W];
    assign w_order  = (i_depth_order > LVL_W'(MAX_ORDER)) ? LVL_W'(MAX_ORDER)
                                                           : i_depth_order;
    assign w_diff_x = OP_W'(r_x1) - OP_W'(r_x0);
    assign w_diff_y = OP_W'(r_y1) - OP_W'(r_y0);
    // Rounded Q16 result of the accumulator: an arithmetic shift by sixteen.
    assign w_acc_q  = w_acc[FRAC_BITS+W+1:FRAC_BITS];

    // Stack ports and the shared multiply-accumulate controls.
    always_comb begin
        w_push    = (r_state == S_P1) || (r_state == S_P2) ||
                    (r_state == S_P3) || (r_state == S_P4);
        w_wr_en   = 1'b0;
        w_wr_addr = r_top[AW-1:0];
        w_wr_data = {r_lvl, r_x0, r_y0, r_ax, r_ay};
        w_rd_en   = 1'b0;
        w_mac_ctl = '0;
        w_mac_a   = w_diff_x;
        w_mac_b   = C_THIRD_Q16;
        case (r_state)
            S_IDLE: begin
                w_wr_en   = i_start;
                w_wr_addr = '0;
                w_wr_data = {w_order, i_start_x, i_start_y, i_end_x, i_end_y};
            end
            S_POP: begin
                w_rd_en = 1'b1;
            end
            S_EXAM: begin
                w_rd_en = (w_rd_lvl == '0) && (r_top != '0);
            end
            S_DX: begin
                w_mac_ctl = '{en: 1'b1, accum: 1'b0, sub: 1'b0};
            end
            S_DY: begin
                w_mac_ctl = '{en: 1'b1, accum: 1'b0, sub: 1'b0};
                w_mac_a   = w_diff_y;
            end
            S_CX0: begin
                w_mac_ctl = '{en: 1'b1, accum: 1'b0, sub: 1'b0};
                w_mac_a   = r_dx;
                w_mac_b   = C_COS60_Q16;
            end
            S_CX1: begin
                w_mac_ctl = '{en: 1'b1, accum: 1'b1, sub: 1'b1};
                w_mac_a   = r_dy;
                w_mac_b   = C_SIN60_Q16;
            end
            S_CY0: begin
                w_mac_ctl = '{en: 1'b1, accum: 1'b0, sub: 1'b0};
                w_mac_a   = r_dx;
                w_mac_b   = C_SIN60_Q16;
            end
            S_CY1: begin
                w_mac_ctl = '{en: 1'b1, accum: 1'b1, sub: 1'b0};
                w_mac_a   = r_dy;
                w_mac_b   = C_COS60_Q16;
            end
            S_P1: begin
                w_wr_data = {r_lvl, r_bx, r_by, r_x1, r_y1};
            end
            S_P2: begin
                w_wr_data = {r_lvl, r_cx, r_cy, r_bx, r_by};
            end
            S_P3: begin
                w_wr_data = {r_lvl, r_ax, r_ay, r_cx, r_cy};
            end
            S_P4: begin
                w_wr_data = {r_lvl, r_x0, r_y0, r_ax, r_ay};
            end
            default: begin
                w_rd_en = 1'b0;
            end
        endcase
        if (w_push) begin
            w_wr_en = (r_top < TW'(DEPTH));
        end
    end

    kcsg_ram #(
        .WIDTH (ENT_W),
        .DEPTH (DEPTH),
        .ADDR_W(AW)
    ) u_stack (
        .i_clk    (i_clk),
        .i_wr_en  (w_wr_en),
        .i_wr_addr(w_wr_addr),
        .i_wr_data(w_wr_data),
        .i_rd_en  (w_rd_en),
        .i_rd_addr(w_top_m1[AW-1:0]),
        .o_rd_data(w_rd_data)
    );

    kcsg_mac #(
        .OP_W (OP_W),
        .ACC_W(ACC_W)
    ) u_mac (
        .i_clk(i_clk),
        .i_ctl(w_mac_ctl),
        .i_a  (w_mac_a),
        .i_b  (w_mac_b),
        .o_acc(w_acc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_top   <= '0;
            r_valid <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_top   <= TW'(1);
                        r_state <= S_POP;
                    end
                end
                S_POP: begin
                    r_top   <= w_top_m1;
                    r_state <= S_EXAM;
                end
                S_EXAM: begin
                    if (w_rd_lvl == '0) begin
                        r_valid  <= 1'b1;
                        r_last   <= (r_top == '0);
                        r_out_sx <= w_rd_data[4*W-1:3*W];
                        r_out_sy <= w_rd_data[3*W-1:2*W];
                        r_out_ex <= w_rd_data[2*W-1:W];
                        r_out_ey <= w_rd_data[W-1:0];
                        // A leaf pops the next entry at once: one beat a cycle while leaves follow.
                        if (r_top != '0) begin
                            r_top <= w_top_m1;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_x0    <= w_rd_data[4*W-1:3*W];
                        r_y0    <= w_rd_data[3*W-1:2*W];
                        r_x1    <= w_rd_data[2*W-1:W];
                        r_y1    <= w_rd_data[W-1:0];
                        r_lvl   <= w_rd_lvl - LVL_W'(1);
                        r_state <= S_DX;
                    end
                end
                S_DX: begin
                    r_state <= S_DY;
                end
                S_DY: begin
                    r_dx    <= w_acc_q[W:0];
                    r_state <= S_CX0;
                end
                S_CX0: begin
                    r_dy    <= w_acc_q[W:0];
                    r_state <= S_CX1;
                end
                S_CX1: begin
                    r_ax    <= sat(SW'(r_x0) + SW'(r_dx));
                    r_ay    <= sat(SW'(r_y0) + SW'(r_dy));
                    r_bx    <= sat(SW'(r_x0) + SW'(r_dx) + SW'(r_dx));
                    r_by    <= sat(SW'(r_y0) + SW'(r_dy) + SW'(r_dy));
                    r_state <= S_CY0;
                end
                S_CY0: begin
                    r_cx_off <= w_acc_q;
                    r_state  <= S_CY1;
                end
                S_CY1: begin
                    r_state <= S_CFIN;
                end
                S_CFIN: begin
                    // The apex is built from the already saturated one-third point.
                    r_cx    <= sat(SW'(r_ax) + SW'(r_cx_off));
                    r_cy    <= sat(SW'(r_ay) + SW'(w_acc_q));
                    r_state <= S_P1;
                end
                S_P1, S_P2, S_P3: begin
                    if (w_wr_en) begin
                        r_top <= r_top + TW'(1);
                    end
                    r_state <= t_state'(r_state + 4'd1);
                end
                S_P4: begin
                    if (w_wr_en) begin
                        r_top <= r_top + TW'(1);
                    end
                    r_state <= S_POP;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_valid        = r_valid;
    assign o_last_segment = r_last;
    assign o_out_start_x  = r_out_sx;
    assign o_out_start_y  = r_out_sy;
    assign o_out_end_x    = r_out_ex;
    assign o_out_end_y    = r_out_ey;

endmodule

// ----- rtl/kcsg_checker.sv -----
`include "koch_curve_segment_generator_top_assert.svh"

module kcsg_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic o_busy,
    input  logic o_valid,
    input  logic o_last_segment
);

    // A taken command keeps the block busy at least until its first beat.
    `KCSG_ASSERT_NXT(a_accept_busy, i_start && !o_busy, o_busy && !o_valid, "accept did not raise busy")

    // More beats are still owed after a beat that is not the last one.
    `KCSG_ASSERT_IMP(a_mid_busy, o_valid && !o_last_segment, o_busy, "busy dropped before last beat")

    // The last beat is shown in the first idle cycle.
    `KCSG_ASSERT_IMP(a_last_idle, o_valid && o_last_segment, !o_busy, "busy held after last beat")

    // Busy only falls together with the last beat of a command.
    `KCSG_ASSERT_IMP(a_fall_last, $fell(o_busy), o_valid && o_last_segment, "busy fell without last beat")

endmodule

bind koch_curve_segment_generator_top kcsg_checker u_kcsg_checker (.*);

// ----- bench/tb.sv -----
`timescale 1ns / 100ps

module tb;

    localparam int     CW        = kcsg_pkg::DEF_COORD_WIDTH;
    localparam longint COORD_MAX = (longint'(1) << (CW - 1)) - 1;
    localparam longint COORD_MIN = -COORD_MAX - 1;
    // One third, cos 60 and sin 60, all in Q0.16.
    localparam longint ONE_THIRD_Q16 = 21845;
    localparam longint COS_60_Q16    = 32768;
    localparam longint SIN_60_Q16    = 56756;
    localparam int     N_DIRECTED    = 18;
    localparam int     N_RANDOM      = 480;

    typedef logic signed [CW-1:0] coord_t;

    typedef struct {
        coord_t sx, sy, ex, ey;
        logic   last;
    } seg_t;

    typedef struct {
        coord_t      sx, sy, ex, ey;
        int unsigned level;
    } pend_t;

    class koch_tracker;
        seg_t expected_segs[$];
        int   errors;
        int   segs_checked;

        function new();
            errors = 0;
            segs_checked = 0;
        endfunction

        static function coord_t clamp(longint v);
            if (v > COORD_MAX) return coord_t'(COORD_MAX);
            if (v < COORD_MIN) return coord_t'(COORD_MIN);
            return coord_t'(v);
        endfunction

        // Adds half an LSB and floors, so halves go towards plus infinity.
        static function longint round_q16(longint p);
            return (p + 32768) >>> 16;
        endfunction

        // Expands one accepted command into its Koch segments in drawing order.
        function void note_command(coord_t sx, coord_t sy, coord_t ex, coord_t ey,
                                   logic [1:0] order);
            pend_t  pending[$];
            pend_t  s;
            longint dx, dy;
            coord_t ax, ay, bx, by, cx, cy;
            pending.push_back('{sx, sy, ex, ey, order});
            while (pending.size() > 0) begin
                s = pending.pop_back();
                if (s.level == 0) begin
                    expected_segs.push_back('{s.sx, s.sy, s.ex, s.ey, pending.size() == 0});
                end else begin
                    dx = round_q16((longint'(s.ex) - longint'(s.sx)) * ONE_THIRD_Q16);
                    dy = round_q16((longint'(s.ey) - longint'(s.sy)) * ONE_THIRD_Q16);
                    ax = clamp(longint'(s.sx) + dx);
                    ay = clamp(longint'(s.sy) + dy);
                    bx = clamp(longint'(s.sx) + 2 * dx);
                    by = clamp(longint'(s.sy) + 2 * dy);
                    // The apex is built from the already saturated one-third point.
                    cx = clamp(longint'(ax) + round_q16(COS_60_Q16 * dx - SIN_60_Q16 * dy));
                    cy = clamp(longint'(ay) + round_q16(SIN_60_Q16 * dx + COS_60_Q16 * dy));
                    pending.push_back('{bx, by, s.ex, s.ey, s.level - 1});
                    pending.push_back('{cx, cy, bx, by, s.level - 1});
                    pending.push_back('{ax, ay, cx, cy, s.level - 1});
                    pending.push_back('{s.sx, s.sy, ax, ay, s.level - 1});
                end
            end
        endfunction

        function void compare_field(string what, coord_t want, coord_t got);
            if (got !== want) begin
                $display("%0t: segment %0d %s expected %0d, got %0d",
                         $time, segs_checked, what, want, got);
                errors++;
            end
        endfunction

        function void check_segment(coord_t sx, coord_t sy, coord_t ex, coord_t ey,
                                    logic last);
            seg_t want;
            if (expected_segs.size() == 0) begin
                $display("%0t: unexpected segment (%0d,%0d)->(%0d,%0d) last %b",
                         $time, sx, sy, ex, ey, last);
                errors++;
                return;
            end
            want = expected_segs.pop_front();
            compare_field("start x", want.sx, sx);
            compare_field("start y", want.sy, sy);
            compare_field("end x", want.ex, ex);
            compare_field("end y", want.ey, ey);
            compare_field("last flag", coord_t'(want.last), coord_t'(last));
            segs_checked++;
        endfunction

        function void report_leftovers();
            if (expected_segs.size() != 0) begin
                $display("%0t: %0d segments never arrived, next expected (%0d,%0d)->(%0d,%0d)",
                         $time, expected_segs.size(), expected_segs[0].sx,
                         expected_segs[0].sy, expected_segs[0].ex, expected_segs[0].ey);
                errors++;
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_start;
    logic       o_busy;
    coord_t     i_start_x, i_start_y, i_end_x, i_end_y;
    logic [1:0] i_depth_order;
    logic       o_valid;
    coord_t     o_out_start_x, o_out_start_y, o_out_end_x, o_out_end_y;
    logic       o_last_segment;

    koch_tracker tracker;
    bit          gaps_on;
    int          per_order[4];

    // Directed commands: start x, start y, end x, end y, order.
    int directed_cmds[N_DIRECTED][5] = '{
        '{0, 0, 0, 0, 0},
        '{256, 0, 768, 0, 0},
        '{32767, 32767, -32768, -32768, 0},
        '{-32768, -32768, 32767, 32767, 1},
        '{-32768, 32767, 32767, 32767, 2},
        '{32767, -32768, -32768, 32767, 3},
        '{0, 0, 1, 0, 1},
        '{0, 0, 3, 0, 1},
        '{0, 0, -1, -1, 2},
        '{0, 0, 768, 0, 1},
        '{0, 0, 768, 0, 2},
        '{0, 0, 768, 0, 3},
        '{0, 0, 0, -32768, 3},
        '{-1, -1, -1, -1, 3},
        '{100, -200, -300, 400, 2},
        '{21845, -21846, -21846, 21845, 1},
        '{0, 0, 6, 0, 3},
        '{32767, 0, -32768, 0, 2}
    };

    koch_curve_segment_generator_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_start_x      (i_start_x),
        .i_start_y      (i_start_y),
        .i_end_x        (i_end_x),
        .i_end_y        (i_end_y),
        .i_depth_order  (i_depth_order),
        .o_valid        (o_valid),
        .o_out_start_x  (o_out_start_x),
        .o_out_start_y  (o_out_start_y),
        .o_out_end_x    (o_out_end_x),
        .o_out_end_y    (o_out_end_y),
        .o_last_segment (o_last_segment)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (o_valid === 1'b1) begin
                tracker.check_segment(o_out_start_x, o_out_start_y, o_out_end_x,
                                      o_out_end_y, o_last_segment);
            end else if (o_valid !== 1'b0) begin
                $display("%0t: result strobe is unknown", $time);
                tracker.errors++;
            end
        end
    end

    // The tasks below drive the inputs with nonblocking assignments and advance on clock edges.
    task automatic drive_idle(int cycles);
        repeat (cycles) begin
            i_start       <= 1'b0;
            i_start_x     <= coord_t'($urandom);
            i_start_y     <= coord_t'($urandom);
            i_end_x       <= coord_t'($urandom);
            i_end_y       <= coord_t'($urandom);
            i_depth_order <= 2'($urandom);
            @(posedge i_clk);
        end
    endtask

    task automatic send_command(coord_t sx, coord_t sy, coord_t ex, coord_t ey,
                                logic [1:0] order);
        i_start       <= 1'b1;
        i_start_x     <= sx;
        i_start_y     <= sy;
        i_end_x       <= ex;
        i_end_y       <= ey;
        i_depth_order <= order;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        tracker.note_command(sx, sy, ex, ey, order);
        per_order[order]++;
    endtask

    task automatic wait_drained();
        do begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end while (tracker.expected_segs.size() > 0);
    endtask

    task automatic maybe_gap();
        if (gaps_on && $urandom_range(99) < 32) begin
            // Mostly short gaps, now and then one long enough to span a whole command.
            if ($urandom_range(7) == 0) drive_idle($urandom_range(20, 360));
            else drive_idle($urandom_range(1, 12));
        end
    endtask

    function automatic coord_t random_coord();
        case ($urandom_range(4))
            0: return coord_t'($urandom);
            1: return coord_t'($urandom_range(1023) - 512);
            2: return coord_t'(COORD_MAX - $urandom_range(63));
            3: return coord_t'(COORD_MIN + $urandom_range(63));
            default: begin
                case ($urandom_range(3))
                    0: return coord_t'(COORD_MAX);
                    1: return coord_t'(COORD_MIN);
                    2: return coord_t'(0);
                    default: return coord_t'(-1);
                endcase
            end
        endcase
    endfunction

    initial begin
        coord_t sx, sy, ex, ey;
        tracker = new();
        gaps_on = 1'b1;
        i_rst_n       <= 1'b0;
        i_start       <= 1'b0;
        i_start_x     <= '0;
        i_start_y     <= '0;
        i_end_x       <= '0;
        i_end_y       <= '0;
        i_depth_order <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int n = 0; n < N_DIRECTED; n++) begin
            send_command(coord_t'(directed_cmds[n][0]), coord_t'(directed_cmds[n][1]),
                         coord_t'(directed_cmds[n][2]), coord_t'(directed_cmds[n][3]),
                         2'(directed_cmds[n][4]));
            maybe_gap();
        end
        wait_drained();

        for (int n = 0; n < N_RANDOM; n++) begin
            // A stretch in the middle runs with no random gaps, though the periodic drain still falls in it.
            gaps_on = !(n >= 150 && n < 300);
            if (n % 120 == 60) wait_drained();
            sx = random_coord();
            sy = random_coord();
            if ($urandom_range(2) == 0) begin
                // End point near the start, so the saturation rarely kicks in.
                ex = coord_t'(longint'(sx) + $urandom_range(4095) - 2048);
                ey = coord_t'(longint'(sy) + $urandom_range(4095) - 2048);
            end else begin
                ex = random_coord();
                ey = random_coord();
            end
            send_command(sx, sy, ex, ey, 2'($urandom_range(3)));
            maybe_gap();
        end

        wait_drained();
        // Keep the inputs idle to catch any stray beat after the last one.
        drive_idle(16);
        tracker.report_leftovers();
        $display("Covered %0d commands (order 0: %0d, 1: %0d, 2: %0d, 3: %0d),",
                 per_order[0] + per_order[1] + per_order[2] + per_order[3],
                 per_order[0], per_order[1], per_order[2], per_order[3]);
        $display("with %0d segments checked against the prediction.", tracker.segs_checked);
        if (tracker.errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("Timed out waiting for the block.");
        $display("end of test: mismatches");
        $finish;
    end

endmodule
